/* rtl/core/kvtp_pkg.sv */
// ----------------------------------------------------------------------------
// kvtp_pkg
// Shared beat types, protocol characters and codes for the request parser.
// ----------------------------------------------------------------------------
package kvtp_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       new_connection;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [1:0]  command;
        logic [7:0]  byte_value;
        logic [13:0] value_length;
        logic [1:0]  error_code;
        logic        last;
    } out_beat_t;

    // parser phases
    localparam logic [1:0] PH_GAP   = 2'd0;
    localparam logic [1:0] PH_WORD  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_TRAIL = 2'd3;

    // event codes
    localparam logic [1:0] EV_KEY   = 2'd0;
    localparam logic [1:0] EV_READY = 2'd1;
    localparam logic [1:0] EV_VALUE = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // command codes
    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_DEL = 2'd1;
    localparam logic [1:0] CMD_ADD = 2'd2;
    localparam logic [1:0] CMD_SET = 2'd3;

    // error codes
    localparam logic [1:0] ERR_LINE_END = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
    localparam logic [1:0] ERR_MISSING  = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    // characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [23:0] WORD_GET = "get";
    localparam logic [23:0] WORD_DEL = "del";
    localparam logic [23:0] WORD_ADD = "add";
    localparam logic [23:0] WORD_SET = "set";

    localparam logic [2:0] FWL_FULL = 3'd3;
    localparam logic [2:0] FWL_OVER = 3'd4;

    // returns {hit, command}
    function automatic logic [2:0] lookup(input logic [23:0] fw, input logic [2:0] fwl);
        logic [2:0] r;
        r = 3'b000;
        if (fwl == FWL_FULL)
        begin
            if (fw == WORD_GET)
                r = {1'b1, CMD_GET};
            else if (fw == WORD_DEL)
                r = {1'b1, CMD_DEL};
            else if (fw == WORD_ADD)
                r = {1'b1, CMD_ADD};
            else if (fw == WORD_SET)
                r = {1'b1, CMD_SET};
        end
        return r;
    endfunction

endpackage

/* rtl/core/kvtp_parser.sv */
// ----------------------------------------------------------------------------
// kvtp_parser
// Parser state registers and the one-beat update that yields at most one
// result per accepted request byte.
// ----------------------------------------------------------------------------
module kvtp_parser #(
    parameter int BUFFER_BYTES = 8192
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 beat,
    input  kvtp_pkg::in_beat_t   in_item,
    output logic                 res_valid,
    output kvtp_pkg::out_beat_t  res
);

    localparam int BS_W    = $clog2(BUFFER_BYTES + 2);
    localparam int SUM_W   = ((BS_W > 14) ? BS_W : 14) + 2;
    localparam int CAP_INT = (BUFFER_BYTES < 16383) ? BUFFER_BYTES : 16383;
    localparam logic [13:0]      COUNT_CAP = 14'(CAP_INT);
    localparam logic [BS_W-1:0]  BUF_LIM   = BS_W'(BUFFER_BYTES);
    localparam logic [SUM_W-1:0] BUF_SUM   = SUM_W'(BUFFER_BYTES);

    logic [1:0]      phase_reg, phase_next, phase_c;
    logic [1:0]      wn_reg, wn_next, wn_c;
    logic [1:0]      cc_reg, cc_next, cc_c;
    logic [23:0]     fw_reg, fw_next, fw_c;
    logic [2:0]      fwl_reg, fwl_next, fwl_c;
    logic [7:0]      hb_reg, hb_next, hb_c;
    logic            hv_reg, hv_next, hv_c;
    logic [13:0]     dl_reg, dl_next, dl_c;
    logic [BS_W-1:0] bs_reg, bs_next, bs_c;
    logic            kp_reg, kp_next, kp_c;
    logic            cp_reg, cp_next, cp_c;
    logic            halted_reg, halted_next, halted_c;
    logic            cs_reg, cs_next, cs_c;

    always_comb
    begin
        logic [7:0]       b;
        logic [7:0]       c;
        logic [2:0]       lk;
        logic [BS_W-1:0]  bs1;
        logic             do_clear;
        logic             first;
        logic             sign;
        logic             cs_v;
        logic [13:0]      dl_v;
        logic [17:0]      v;

        b = in_item.byte_in;
        c = hb_reg;
        do_clear = 1'b0;
        first = 1'b0;
        sign = 1'b0;
        cs_v = 1'b0;
        dl_v = '0;
        v = '0;

        phase_c  = phase_reg;
        wn_c     = wn_reg;
        cc_c     = cc_reg;
        fw_c     = fw_reg;
        fwl_c    = fwl_reg;
        hb_c     = hb_reg;
        hv_c     = hv_reg;
        dl_c     = dl_reg;
        bs_c     = bs_reg;
        kp_c     = kp_reg;
        cp_c     = cp_reg;
        halted_c = halted_reg;
        cs_c     = cs_reg;
        if (in_item.new_connection)
        begin
            phase_c  = kvtp_pkg::PH_GAP;
            wn_c     = '0;
            cc_c     = '0;
            fw_c     = '0;
            fwl_c    = '0;
            hb_c     = '0;
            hv_c     = 1'b0;
            dl_c     = '0;
            bs_c     = '0;
            kp_c     = 1'b0;
            cp_c     = 1'b0;
            halted_c = 1'b0;
            cs_c     = 1'b0;
        end
        c  = hb_c;
        lk = kvtp_pkg::lookup(fw_c, fwl_c);
        bs1 = bs_c + BS_W'(1);

        phase_next  = phase_c;
        wn_next     = wn_c;
        cc_next     = cc_c;
        fw_next     = fw_c;
        fwl_next    = fwl_c;
        hb_next     = hb_c;
        hv_next     = hv_c;
        dl_next     = dl_c;
        bs_next     = bs_c;
        kp_next     = kp_c;
        cp_next     = cp_c;
        halted_next = halted_c;
        cs_next     = cs_c;

        res_valid = 1'b0;
        res       = '0;

        if (!halted_c)
        begin
            unique case (phase_c)
                kvtp_pkg::PH_VALUE:
                begin
                    res_valid = 1'b1;
                    res.event_res    = kvtp_pkg::EV_VALUE;
                    res.command      = cc_c;
                    res.byte_value   = b;
                    res.value_length = dl_c;
                    if (SUM_W'(bs1) >= SUM_W'(dl_c))
                    begin
                        res.last   = 1'b1;
                        phase_next = kvtp_pkg::PH_TRAIL;
                        bs_next    = '0;
                    end
                    else
                    begin
                        bs_next = bs1;
                    end
                end
                kvtp_pkg::PH_TRAIL:
                begin
                    bs_next = bs1;
                    if (bs1 >= BS_W'(2))
                        do_clear = 1'b1;
                end
                default:
                begin
                    bs_next = bs1;
                    if (bs1 > BUF_LIM)
                    begin
                        halted_next = 1'b1;
                        res_valid = 1'b1;
                        res.event_res  = kvtp_pkg::EV_ERROR;
                        res.error_code = kvtp_pkg::ERR_TOO_LONG;
                        res.last       = 1'b1;
                    end
                    else if (b == kvtp_pkg::CH_LF)
                    begin
                        res_valid = 1'b1;
                        res.event_res = kvtp_pkg::EV_ERROR;
                        res.last      = 1'b1;
                        if (!(hv_c && hb_c == kvtp_pkg::CH_CR))
                        begin
                            halted_next = 1'b1;
                            res.error_code = kvtp_pkg::ERR_LINE_END;
                        end
                        else if (!lk[2])
                        begin
                            halted_next = 1'b1;
                            res.error_code = kvtp_pkg::ERR_UNKNOWN;
                        end
                        else if (!kp_c || (lk[1] && !cp_c))
                        begin
                            halted_next = 1'b1;
                            res.error_code = kvtp_pkg::ERR_MISSING;
                        end
                        else if (!lk[1])
                        begin
                            // get or del complete at the line end
                            do_clear = 1'b1;
                            res.event_res = kvtp_pkg::EV_READY;
                            res.command   = lk[1:0];
                        end
                        else if (SUM_W'(bs1) + SUM_W'(dl_c) + SUM_W'(2) > BUF_SUM)
                        begin
                            halted_next = 1'b1;
                            res.error_code = kvtp_pkg::ERR_TOO_LONG;
                        end
                        else
                        begin
                            cc_next = lk[1:0];
                            hv_next = 1'b0;
                            bs_next = '0;
                            phase_next = (dl_c == '0) ? kvtp_pkg::PH_TRAIL
                                                      : kvtp_pkg::PH_VALUE;
                            res.event_res    = kvtp_pkg::EV_READY;
                            res.command      = lk[1:0];
                            res.value_length = dl_c;
                            res.last         = (dl_c == '0);
                        end
                    end
                    else
                    begin
                        // held byte is now known not to be the CR of a line end
                        if (hv_c)
                        begin
                            if (c == kvtp_pkg::CH_SP)
                            begin
                                if (phase_c == kvtp_pkg::PH_WORD)
                                begin
                                    if (wn_c == 2'd0)
                                        cc_next = lk[2] ? lk[1:0] : kvtp_pkg::CMD_GET;
                                    if (wn_c != 2'd3)
                                        wn_next = wn_c + 2'd1;
                                    phase_next = kvtp_pkg::PH_GAP;
                                end
                            end
                            else
                            begin
                                first = (phase_c != kvtp_pkg::PH_WORD);
                                phase_next = kvtp_pkg::PH_WORD;
                                case (wn_c)
                                    2'd0:
                                    begin
                                        if (fwl_c < kvtp_pkg::FWL_FULL)
                                        begin
                                            fw_next  = {fw_c[15:0], c};
                                            fwl_next = fwl_c + 3'd1;
                                        end
                                        else
                                        begin
                                            fwl_next = kvtp_pkg::FWL_OVER;
                                        end
                                    end
                                    2'd1:
                                    begin
                                        kp_next = 1'b1;
                                        if (lk[2])
                                        begin
                                            res_valid = 1'b1;
                                            res.event_res  = kvtp_pkg::EV_KEY;
                                            res.command    = lk[1:0];
                                            res.byte_value = c;
                                        end
                                    end
                                    2'd2:
                                    begin
                                        cs_v = cs_c;
                                        dl_v = dl_c;
                                        if (first)
                                        begin
                                            cp_next = 1'b1;
                                            cs_v = 1'b0;
                                            dl_v = '0;
                                            if (c == kvtp_pkg::CH_PLUS
                                                || c == kvtp_pkg::CH_MINUS)
                                            begin
                                                cs_v = (c == kvtp_pkg::CH_MINUS);
                                                sign = 1'b1;
                                            end
                                        end
                                        if (!sign && !cs_v)
                                        begin
                                            if (c >= kvtp_pkg::CH_ZERO
                                                && c <= kvtp_pkg::CH_NINE)
                                            begin
                                                v = (18'(dl_v) << 3) + (18'(dl_v) << 1)
                                                    + 18'(c - kvtp_pkg::CH_ZERO);
                                                dl_v = (v > 18'(COUNT_CAP)) ? COUNT_CAP
                                                                             : v[13:0];
                                            end
                                            else
                                            begin
                                                cs_v = 1'b1;
                                            end
                                        end
                                        cs_next = cs_v;
                                        dl_next = dl_v;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        hb_next = b;
                        hv_next = 1'b1;
                    end
                end
            endcase
        end

        if (do_clear)
        begin
            phase_next = kvtp_pkg::PH_GAP;
            wn_next    = '0;
            cc_next    = '0;
            fw_next    = '0;
            fwl_next   = '0;
            hb_next    = '0;
            hv_next    = 1'b0;
            dl_next    = '0;
            bs_next    = '0;
            kp_next    = 1'b0;
            cp_next    = 1'b0;
            cs_next    = 1'b0;
        end

        if (!beat)
            res_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= kvtp_pkg::PH_GAP;
            wn_reg     <= '0;
            cc_reg     <= '0;
            fw_reg     <= '0;
            fwl_reg    <= '0;
            hb_reg     <= '0;
            hv_reg     <= 1'b0;
            dl_reg     <= '0;
            bs_reg     <= '0;
            kp_reg     <= 1'b0;
            cp_reg     <= 1'b0;
            halted_reg <= 1'b0;
            cs_reg     <= 1'b0;
        end
        else if (beat)
        begin
            phase_reg  <= phase_next;
            wn_reg     <= wn_next;
            cc_reg     <= cc_next;
            fw_reg     <= fw_next;
            fwl_reg    <= fwl_next;
            hb_reg     <= hb_next;
            hv_reg     <= hv_next;
            dl_reg     <= dl_next;
            bs_reg     <= bs_next;
            kp_reg     <= kp_next;
            cp_reg     <= cp_next;
            halted_reg <= halted_next;
            cs_reg     <= cs_next;
        end
    end

endmodule

/* rtl/core/kvtp_out_skid.sv */
// ----------------------------------------------------------------------------
// kvtp_out_skid
// Result register with one skid entry so a new beat can be taken while the
// current result waits on a stalled consumer.
// ----------------------------------------------------------------------------
module kvtp_out_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kvtp_pkg::out_beat_t  push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output kvtp_pkg::out_beat_t  out_data
);

    logic                main_valid_reg;
    logic                skid_valid_reg;
    kvtp_pkg::out_beat_t main_reg;
    kvtp_pkg::out_beat_t skid_reg;
    logic                freed;

    assign freed     = !main_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (freed)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (freed)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (freed)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (freed)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (freed)
                main_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

endmodule

/* rtl/core/kv_text_request_parser_unit.sv */
// results are registered in the result register, or in its skid entry on a stall
// throughput: one request byte per cycle unless req_stall is high
// req_stall rises only while the result register and its skid entry are both full
// reset (rst_n low, asynchronous) clears parser state and empties both result entries
// ----------------------------------------------------------------------------
// kv_text_request_parser_unit
// Text key/value request parser: splits request lines, passes out key and
// value bytes, request-ready and error events.
// ----------------------------------------------------------------------------
module kv_text_request_parser_unit #(
    parameter int BUFFER_BYTES = 8192
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  kvtp_pkg::in_beat_t   req_data,
    output logic                 evt_valid,
    input  logic                 evt_stall,
    output kvtp_pkg::out_beat_t  evt_data
);

    logic                beat;
    logic                res_valid;
    kvtp_pkg::out_beat_t res;
    logic                skid_full;

    assign req_stall = skid_full;
    assign beat      = req_valid && !skid_full;

    kvtp_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .in_item   (req_data),
        .res_valid (res_valid),
        .res       (res)
    );

    kvtp_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (skid_full),
        .out_valid (evt_valid),
        .out_stall (evt_stall),
        .out_data  (evt_data)
    );

endmodule

/* rtl/core/kvtp_checker.sv */
// ----------------------------------------------------------------------------
// kvtp_checker
// Port-level checks on the request parser, bound to the top level.
// ----------------------------------------------------------------------------
module kvtp_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_stall,
    input  logic                 evt_valid,
    input  logic                 evt_stall,
    input  kvtp_pkg::out_beat_t  evt_data
);

    // stalled result beat holds
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt_data))
        else $error("result beat changed under stall");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> evt_valid && $past(evt_valid && evt_stall))
        else $error("request stall without stalled result");

    // every error ends the request
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_data.event_res == kvtp_pkg::EV_ERROR |-> evt_data.last)
        else $error("error beat without last");

    // key bytes never end a request and carry no length
    a_key_beat: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_data.event_res == kvtp_pkg::EV_KEY
        |-> !evt_data.last && evt_data.value_length == '0)
        else $error("bad key beat");

    // get and del ready is final and has no length
    a_ready_short: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_data.event_res == kvtp_pkg::EV_READY
        && (evt_data.command == kvtp_pkg::CMD_GET || evt_data.command == kvtp_pkg::CMD_DEL)
        |-> evt_data.last && evt_data.value_length == '0)
        else $error("bad ready beat for get or del");

endmodule

bind kv_text_request_parser_unit kvtp_checker u_checker (.*);
